// ----- rtl/core/ordered_list_engine_macros.svh -----
// Assertion helpers for the list engine datapath (ole_dp).
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define OLE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ordered_list_engine assertion failed");

// Next-cycle implication, checked outside reset.
`define OLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ordered_list_engine assertion failed");

`endif

// ----- rtl/core/ole_pkg.sv -----
package ole_pkg;

    localparam int LIST_DEPTH = 64;

    localparam int REQ_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    typedef logic [REQ_W-1:0]    req_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam req_t REQ_APPEND = 3'd0;
    localparam req_t REQ_SEARCH = 3'd1;
    localparam req_t REQ_SUM    = 3'd2;
    localparam req_t REQ_REMOVE = 3'd3;
    localparam req_t REQ_INSERT = 3'd4;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_SHIFT,
        S_WRITE,
        S_RM_ISSUE,
        S_RM_TAKE,
        S_FINISH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic walk_issue;
        logic shift_issue;
        logic rm_take;
        logic write_new;
        logic out_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic op_append;
        logic op_search;
        logic op_sum;
        logic op_remove;
        logic op_insert;
        logic full;
        logic empty;
        logic idx_lt_len;
        logic idx_gt_slot;
        logic found;
        logic rd_pend;
        logic out_free;
    } sts_t;

endpackage

// ----- rtl/core/ole_ram.sv -----
module ole_ram #(
    parameter int WIDTH = ole_pkg::VALUE_W,
    parameter int DEPTH = ole_pkg::LIST_DEPTH
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/ole_ctrl.sv -----
module ole_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  ole_pkg::sts_t sts,
    output ole_pkg::cmd_t cmd
);

    ole_pkg::state_t state_reg;
    ole_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ole_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ole_pkg::S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ole_pkg::S_DECODE;
                end
            end
            ole_pkg::S_DECODE: begin
                if (sts.op_append || sts.op_insert) begin
                    state_next = sts.full ? ole_pkg::S_FINISH : ole_pkg::S_SHIFT;
                end else if (sts.op_search || sts.op_sum) begin
                    state_next = ole_pkg::S_WALK;
                end else if (sts.op_remove) begin
                    state_next = sts.empty ? ole_pkg::S_FINISH : ole_pkg::S_RM_ISSUE;
                end else begin
                    state_next = ole_pkg::S_FINISH;
                end
            end
            ole_pkg::S_WALK: begin
                cmd.walk_issue = sts.idx_lt_len && !sts.found;
                if (!cmd.walk_issue && !sts.rd_pend) begin
                    state_next = ole_pkg::S_FINISH;
                end
            end
            ole_pkg::S_SHIFT: begin
                cmd.shift_issue = sts.idx_gt_slot;
                if (!cmd.shift_issue && !sts.rd_pend) begin
                    state_next = ole_pkg::S_WRITE;
                end
            end
            ole_pkg::S_WRITE: begin
                cmd.write_new = 1'b1;
                state_next    = ole_pkg::S_FINISH;
            end
            ole_pkg::S_RM_ISSUE: begin
                // head read is in flight
                state_next = ole_pkg::S_RM_TAKE;
            end
            ole_pkg::S_RM_TAKE: begin
                cmd.rm_take = 1'b1;
                state_next  = ole_pkg::S_FINISH;
            end
            ole_pkg::S_FINISH: begin
                cmd.out_load = sts.out_free;
                if (sts.out_free) begin
                    state_next = ole_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ole_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/ole_dp.sv -----
`include "ordered_list_engine_macros.svh"

module ole_dp #(
    parameter int DEPTH = ole_pkg::LIST_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ole_pkg::cmd_t                       cmd,
    output ole_pkg::sts_t                       sts,
    input  logic [ole_pkg::REQ_W-1:0]           s_req_type,
    input  logic signed [ole_pkg::VALUE_W-1:0]  s_value,
    input  logic [ole_pkg::POS_W-1:0]           s_position,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic [ole_pkg::STATUS_W-1:0]        m_status,
    output logic                                m_found,
    output logic signed [ole_pkg::VALUE_W-1:0]  m_result_value,
    output logic [ole_pkg::POS_W-1:0]           m_match_position,
    output logic [ole_pkg::COUNT_W-1:0]         m_element_count
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W + 1 > ole_pkg::POS_W) ? CNT_W + 1 : ole_pkg::POS_W;
    localparam logic [CNT_W:0]   DEPTH_EXT = (CNT_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    // circular buffer: logical index -> RAM address
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                              input logic [CNT_W-1:0] i);
        logic [CNT_W:0] s;
        s = {{(CNT_W + 1 - IDX_W){1'b0}}, head} + {1'b0, i};
        if (s >= DEPTH_EXT) begin
            s = s - DEPTH_EXT;
        end
        return s[IDX_W-1:0];
    endfunction

    logic [IDX_W-1:0]             head_reg;
    logic [CNT_W-1:0]             len_reg;
    logic [CNT_W-1:0]             idx_reg;
    logic [CNT_W-1:0]             slot_reg;
    logic [CNT_W-1:0]             rd_idx_reg;
    logic [IDX_W-1:0]             wr_tgt_reg;
    logic                         rd_pend_reg;
    ole_pkg::req_t                req_reg;
    logic [ole_pkg::VALUE_W-1:0]  value_reg;
    logic [ole_pkg::VALUE_W-1:0]  acc_reg;
    logic                         found_reg;
    logic [ole_pkg::POS_W-1:0]    match_reg;
    ole_pkg::status_t             status_reg;
    logic                         m_valid_reg;

    logic                         full;
    logic                         empty;
    logic                         in_app;
    logic                         in_ins;
    logic [CMP_W-1:0]             pos_c;
    logic [CMP_W-1:0]             len_p1;
    logic [CNT_W-1:0]             slot_clamp;
    logic                         shifting;

    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    logic [ole_pkg::VALUE_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]             ram_raddr;
    logic [ole_pkg::VALUE_W-1:0]  ram_rdata;

    assign full     = (len_reg == DEPTH_CNT);
    assign empty    = (len_reg == '0);
    assign in_app   = (s_req_type == ole_pkg::REQ_APPEND);
    assign in_ins   = (s_req_type == ole_pkg::REQ_INSERT);
    assign shifting = (req_reg == ole_pkg::REQ_APPEND) || (req_reg == ole_pkg::REQ_INSERT);

    // position clamp: head for 0/1, tail when past the end
    assign pos_c  = CMP_W'(s_position);
    assign len_p1 = CMP_W'(len_reg) + CMP_W'(1);
    always_comb begin
        if (pos_c == '0) begin
            slot_clamp = '0;
        end else if (pos_c > len_p1) begin
            slot_clamp = len_reg;
        end else begin
            slot_clamp = CNT_W'(pos_c - CMP_W'(1));
        end
    end

    always_comb begin
        sts.op_append   = (req_reg == ole_pkg::REQ_APPEND);
        sts.op_search   = (req_reg == ole_pkg::REQ_SEARCH);
        sts.op_sum      = (req_reg == ole_pkg::REQ_SUM);
        sts.op_remove   = (req_reg == ole_pkg::REQ_REMOVE);
        sts.op_insert   = (req_reg == ole_pkg::REQ_INSERT);
        sts.full        = full;
        sts.empty       = empty;
        sts.idx_lt_len  = (idx_reg < len_reg);
        sts.idx_gt_slot = (idx_reg > slot_reg);
        sts.found       = found_reg;
        sts.rd_pend     = rd_pend_reg;
        sts.out_free    = !m_valid_reg || m_ready;
    end

    // RAM ports
    assign ram_raddr = cmd.shift_issue ? phys(head_reg, idx_reg - CNT_W'(1))
                                       : phys(head_reg, idx_reg);
    assign ram_we    = (rd_pend_reg && shifting) || cmd.write_new;
    assign ram_waddr = cmd.write_new ? phys(head_reg, slot_reg) : wr_tgt_reg;
    assign ram_wdata = cmd.write_new ? value_reg : ram_rdata;

    ole_ram #(
        .WIDTH(ole_pkg::VALUE_W),
        .DEPTH(DEPTH)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            len_reg     <= '0;
            idx_reg     <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            rd_pend_reg <= cmd.walk_issue || cmd.shift_issue;
            if (cmd.load) begin
                idx_reg <= (in_app || in_ins) ? len_reg : '0;
            end else if (cmd.walk_issue) begin
                idx_reg <= idx_reg + CNT_W'(1);
            end else if (cmd.shift_issue) begin
                idx_reg <= idx_reg - CNT_W'(1);
            end
            if (cmd.rm_take) begin
                head_reg <= phys(head_reg, CNT_W'(1));
                len_reg  <= len_reg - CNT_W'(1);
            end else if (cmd.write_new) begin
                len_reg <= len_reg + CNT_W'(1);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg   <= s_req_type;
            value_reg <= s_value;
            slot_reg  <= in_app ? len_reg : slot_clamp;
            acc_reg   <= '0;
            found_reg <= 1'b0;
            match_reg <= '0;
            if ((in_app || in_ins) && full) begin
                status_reg <= ole_pkg::ST_FULL;
            end else if ((s_req_type == ole_pkg::REQ_REMOVE) && empty) begin
                status_reg <= ole_pkg::ST_EMPTY;
            end else begin
                status_reg <= ole_pkg::ST_OK;
            end
        end else begin
            if (rd_pend_reg && sts.op_search && !found_reg && (ram_rdata == value_reg)) begin
                found_reg <= 1'b1;
                match_reg <= ole_pkg::POS_W'(rd_idx_reg) + ole_pkg::POS_W'(1);
            end
            if (rd_pend_reg && sts.op_sum) begin
                acc_reg <= acc_reg + ram_rdata;
            end
            if (cmd.rm_take) begin
                acc_reg <= ram_rdata;
            end
        end
        rd_idx_reg <= idx_reg;
        if (cmd.shift_issue) begin
            wr_tgt_reg <= phys(head_reg, idx_reg);
        end
        if (cmd.out_load) begin
            m_status         <= status_reg;
            m_found          <= found_reg;
            m_result_value   <= acc_reg;
            m_match_position <= match_reg;
            m_element_count  <= ole_pkg::COUNT_W'(len_reg);
        end
    end

    assign m_valid = m_valid_reg;

    `OLE_ASSERT_IMPL(a_len_bound, aclk, aresetn, 1'b1, len_reg <= DEPTH_CNT)
    `OLE_ASSERT_IMPL(a_no_wr_clash, aclk, aresetn, cmd.write_new, !rd_pend_reg)
    `OLE_ASSERT_IMPL(a_out_slot_free, aclk, aresetn, cmd.out_load, !m_valid_reg || m_ready)
    `OLE_ASSERT_IMPL(a_rm_nonempty, aclk, aresetn, cmd.rm_take, !empty)
    `OLE_ASSERT_NEXT(a_rm_len, aclk, aresetn, cmd.rm_take, len_reg == $past(len_reg) - CNT_W'(1))

endmodule

// ----- rtl/core/ordered_list_engine.sv -----
// Ordered list engine: a bounded list of signed 32-bit elements kept in one RAM
// as a circular buffer (head pointer plus length), so removing the head is O(1).
// Input channel (s_*): one request word per handshake: append, search, sum,
// remove head or insert at a 1-based position. Result channel (m_*): exactly
// one result word per request, in order, always carrying the element count.
// Steps from acceptance to result registered (k = slot):
//   append / insert : elements from slot k on are read and written one slot
//                     toward the tail, then the new value is written at slot k
//   search / sum    : one element read per cycle from the head (search stops early)
//   remove head     : head read, then head and length update; unused codes,
//                     refused requests and empty removes go straight to the result.
// One request is worked at a time; the next word is taken the cycle after
// the previous result is registered, even while that result is still
// waiting on m_ready, so a stalled receiver only holds back the finish
// of the following request.
// Reset (aresetn low, synchronous) empties the list and drops any result in
// flight; RAM contents are not cleared and need no clearing pass.
module ordered_list_engine #(
    parameter int LIST_DEPTH = ole_pkg::LIST_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // request channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ole_pkg::REQ_W-1:0]           s_req_type,
    input  logic signed [ole_pkg::VALUE_W-1:0]  s_value,
    input  logic [ole_pkg::POS_W-1:0]           s_position,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ole_pkg::STATUS_W-1:0]        m_status,
    output logic                                m_found,
    output logic signed [ole_pkg::VALUE_W-1:0]  m_result_value,
    output logic [ole_pkg::POS_W-1:0]           m_match_position,
    output logic [ole_pkg::COUNT_W-1:0]         m_element_count
);

    ole_pkg::cmd_t cmd;
    ole_pkg::sts_t sts;

    // sequencer: decides walk / shift / remove steps from datapath status
    ole_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    // datapath: element RAM, head/length, walk index, accumulator, result word
    ole_dp #(
        .DEPTH(LIST_DEPTH)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_req_type      (s_req_type),
        .s_value         (s_value),
        .s_position      (s_position),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_status        (m_status),
        .m_found         (m_found),
        .m_result_value  (m_result_value),
        .m_match_position(m_match_position),
        .m_element_count (m_element_count)
    );

endmodule
